>>> src/rsrd_pkg.sv
// Shared types and constants for the run-length sprite row decoder.
// No dependencies; used by every module of the block by scoped name.
`default_nettype none

package rsrd_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_index;
    logic [15:0] column;
    logic [14:0] row;
    logic        last_of_run;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic step;  // consume the input beat
    logic emit;  // send one pixel of the pending repeat run
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit_now;   // input byte yields exactly one pixel
    logic run_start;  // input byte opens a repeat run
    logic run_last;   // pending run has one pixel left
  } sts_t;

endpackage

`default_nettype wire

>>> src/rsrd_ctrl.sv
// Handshake controller: input acceptance, repeat-run sequencing, output valid.
// Depends on rsrd_pkg for the command and status structs.
`default_nettype none

module rsrd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire rsrd_pkg::sts_t sts_i,
  output rsrd_pkg::cmd_t     cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   load;

  // output slot can take a beat this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.step = (state_q == ST_IDLE) && out_free && in_valid_i;
    cmd_o.emit = (state_q == ST_RUN) && out_free;
    in_stall_o = !((state_q == ST_IDLE) && out_free);
    load       = (cmd_o.step && sts_i.emit_now) || cmd_o.emit;

    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_o.step && sts_i.run_start) state_d = ST_RUN;
      ST_RUN:  if (cmd_o.emit && sts_i.run_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> src/rsrd_dpath.sv
// Datapath: configuration registers, row/column/run state, pixel output register.
// Depends on rsrd_pkg; driven by rsrd_ctrl through cmd_t, reports via sts_t.
`default_nettype none

module rsrd_dpath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rsrd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [rsrd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire rsrd_pkg::in_item_t              in_data_i,
  input  wire rsrd_pkg::cmd_t                  cmd_i,
  output rsrd_pkg::sts_t                       sts_o,
  output rsrd_pkg::out_item_t                  out_data_o
);

  typedef enum logic [2:0] {
    PH_HDR_LO,
    PH_HDR_HI,
    PH_CTRL,
    PH_REPEAT,
    PH_LIT
  } phase_e;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // configuration
  logic        mode_q;
  logic [14:0] width_q;
  logic [14:0] height_q;

  // frame state
  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_lo_q, hdr_lo_d;
  logic [14:0] rbl_q, rbl_d;
  logic [6:0]  lit_q, lit_d;
  logic [14:0] row_q, row_d;
  logic [15:0] col_q, col_d;
  logic [6:0]  rep_q, rep_d;
  logic [7:0]  run_pix_q;

  rsrd_pkg::out_item_t out_q;

  // state seen by the input byte (start of frame clears first)
  phase_e      cur_phase;
  logic [7:0]  cur_hdr_lo;
  logic [14:0] cur_rbl, rbl_dec, hdr_cnt;
  logic [6:0]  cur_lit, lit_dec;
  logic [14:0] cur_row;
  logic [15:0] cur_col, col_inc;
  logic [6:0]  cur_rep;
  logic [16:0] skip_sum;
  logic [7:0]  b;
  logic        emit1, run_start, end_row;

  assign b = in_data_i.data_byte;

  always_comb begin
    if (in_data_i.start_of_frame) begin
      cur_phase  = PH_HDR_LO;
      cur_hdr_lo = '0;
      cur_rbl    = '0;
      cur_lit    = '0;
      cur_row    = '0;
      cur_col    = '0;
      cur_rep    = '0;
    end else begin
      cur_phase  = phase_q;
      cur_hdr_lo = hdr_lo_q;
      cur_rbl    = rbl_q;
      cur_lit    = lit_q;
      cur_row    = row_q;
      cur_col    = col_q;
      cur_rep    = rep_q;
    end
    rbl_dec  = cur_rbl - 15'd1;
    lit_dec  = (cur_lit != '0) ? cur_lit - 7'd1 : '0;
    col_inc  = sat_inc(cur_col);
    skip_sum = {1'b0, cur_col} + 17'(b[7:1]);
    hdr_cnt  = b[7] ? '0 : {b[6:0], cur_hdr_lo};

    phase_d   = phase_q;
    hdr_lo_d  = hdr_lo_q;
    rbl_d     = rbl_q;
    lit_d     = lit_q;
    row_d     = row_q;
    col_d     = col_q;
    rep_d     = rep_q;
    emit1     = 1'b0;
    run_start = 1'b0;
    end_row   = 1'b0;

    if (cmd_i.step) begin
      phase_d  = cur_phase;
      hdr_lo_d = cur_hdr_lo;
      rbl_d    = cur_rbl;
      lit_d    = cur_lit;
      row_d    = cur_row;
      col_d    = cur_col;
      rep_d    = cur_rep;
    end

    // frame complete: byte ignored
    if (cmd_i.step && cur_row < height_q) begin
      if (!mode_q) begin
        if (width_q != '0) begin
          emit1 = 1'b1;
          col_d = col_inc;
          if (col_inc >= {1'b0, width_q}) end_row = 1'b1;
        end
      end else begin
        unique case (cur_phase)
          PH_HDR_HI: begin
            phase_d = PH_CTRL;
            rbl_d   = hdr_cnt;
            if (hdr_cnt == '0) end_row = 1'b1;
          end
          PH_CTRL, PH_REPEAT, PH_LIT: begin
            if (cur_rbl == '0) begin
              end_row = 1'b1;
            end else begin
              rbl_d = rbl_dec;
              if (cur_phase == PH_CTRL) begin
                if (b[0]) begin
                  col_d = skip_sum[16] ? 16'hFFFF : skip_sum[15:0];
                end else if (b[1]) begin
                  rep_d   = {1'b0, b[7:2]} + 7'd1;
                  phase_d = PH_REPEAT;
                end else begin
                  lit_d   = {1'b0, b[7:2]} + 7'd1;
                  phase_d = PH_LIT;
                end
                if (rbl_dec == '0) end_row = 1'b1;
              end else if (cur_phase == PH_REPEAT) begin
                phase_d = PH_CTRL;
                // a run defers the row end to its last pixel
                if (cur_rep != '0) begin
                  run_start = 1'b1;
                end else if (rbl_dec == '0) begin
                  end_row = 1'b1;
                end
              end else begin
                emit1 = 1'b1;
                col_d = col_inc;
                lit_d = lit_dec;
                if (lit_dec == '0) phase_d = PH_CTRL;
                if (rbl_dec == '0) end_row = 1'b1;
              end
            end
          end
          default: begin
            hdr_lo_d = b;
            phase_d  = PH_HDR_HI;
          end
        endcase
      end
    end

    if (cmd_i.emit) begin
      col_d = sat_inc(col_q);
      rep_d = rep_q - 7'd1;
      if (rep_q == 7'd1 && rbl_q == '0) end_row = 1'b1;
    end

    if (end_row && (cmd_i.step || cmd_i.emit)) begin
      row_d   = (cmd_i.emit ? row_q : cur_row) + 15'd1;
      col_d   = '0;
      phase_d = PH_HDR_LO;
      lit_d   = '0;
      rep_d   = '0;
      rbl_d   = '0;
    end
  end

  always_comb begin
    sts_o.emit_now  = emit1;
    sts_o.run_start = run_start;
    sts_o.run_last  = (rep_q == 7'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b1;
      width_q  <= '0;
      height_q <= '0;
      phase_q  <= PH_HDR_LO;
      hdr_lo_q <= '0;
      rbl_q    <= '0;
      lit_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      rep_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rsrd_pkg::CFG_MODE:   mode_q   <= cfg_data_i[0];
          rsrd_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
          rsrd_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.step || cmd_i.emit) begin
        phase_q  <= phase_d;
        hdr_lo_q <= hdr_lo_d;
        rbl_q    <= rbl_d;
        lit_q    <= lit_d;
        row_q    <= row_d;
        col_q    <= col_d;
        rep_q    <= rep_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && run_start) run_pix_q <= b;
    if (cmd_i.emit) begin
      out_q.pixel_index <= run_pix_q;
      out_q.column      <= col_q;
      out_q.row         <= row_q;
      out_q.last_of_run <= (rep_q == 7'd1);
    end else if (cmd_i.step && emit1) begin
      out_q.pixel_index <= b;
      out_q.column      <= cur_col;
      out_q.row         <= cur_row;
      out_q.last_of_run <= 1'b1;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

>>> src/rle_sprite_row_decoder_unit.sv
// Top level of the run-length sprite row decoder: controller plus datapath.
// Depends on rsrd_pkg, rsrd_ctrl and rsrd_dpath.
//
//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+--------------------------
//  in      | into      | in_valid_i / in_stall_o   | in_item_t (byte, sof)
//  out     | out of    | out_valid_o / out_stall_i | out_item_t (one pixel)
//  cfg     | into      | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// A byte is taken every cycle while the output register drains and no run
// is pending. A repeat run holds the input until its last pixel is sent: the
// run counter sends one pixel per cycle, unless out_stall_i holds the output,
// through the single output register.
// Output stall backs up into in_stall_o; no beat is dropped.
// Reset returns to compressed mode, zero width and height, row and column 0.
`default_nettype none

module rle_sprite_row_decoder_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire rsrd_pkg::in_item_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output rsrd_pkg::out_item_t                  out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rsrd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [rsrd_pkg::CfgDataW-1:0]   cfg_data_i
);

  rsrd_pkg::cmd_t cmd;
  rsrd_pkg::sts_t sts;

  rsrd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rsrd_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

>>> src/rsrd_checker.sv
// Port-level checks for the run-length sprite row decoder, bound to the top level.
// Depends on rsrd_pkg and rle_sprite_row_decoder_unit.
`default_nettype none

module rsrd_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire rsrd_pkg::out_item_t             out_data_o
);

  // stalled output beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // a full, stalled output register must hold off the input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output is blocked");

  // mid-run pixel sent: the next pixel of the run follows at once
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("repeat run broken off");

endmodule

bind rle_sprite_row_decoder_unit rsrd_checker u_rsrd_checker (.*);

`default_nettype wire
